// ----- hdl/iol_pkg.sv -----
// Package for the indexed ordered list: field widths, command and status codes, cell control.
`default_nettype none

package iol_pkg;

    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int CMD_WIDTH    = 3;
    localparam int POS_WIDTH    = 8;
    localparam int VALUE_WIDTH  = 32;
    localparam int STATUS_WIDTH = 2;
    localparam int FOUND_WIDTH  = 4;
    localparam int COUNT_WIDTH  = 5;
    localparam int EXT_WIDTH    = 64;

    localparam logic [CMD_WIDTH-1:0] CMD_APPEND  = 3'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_INSERT  = 3'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_DELETE  = 3'd2;
    localparam logic [CMD_WIDTH-1:0] CMD_REPLACE = 3'd3;
    localparam logic [CMD_WIDTH-1:0] CMD_READ    = 3'd4;
    localparam logic [CMD_WIDTH-1:0] CMD_LOCATE  = 3'd5;

    localparam logic [STATUS_WIDTH-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_WIDTH-1:0] ST_NOT_FOUND = 2'd3;

    // Commit order broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic remove;
        logic replace;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- hdl/iol_cell.sv -----
// One cell of the list chain: holds one entry, compares it, shifts with its neighbors.
`default_nettype none

module iol_cell
    import iol_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int KEY_WIDTH  = POS_WIDTH,
    parameter int INDEX      = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_capture,
    input  wire logic [DATA_WIDTH-1:0] i_key,
    input  wire logic [KEY_WIDTH-1:0]  i_pos,
    input  wire logic [KEY_WIDTH-1:0]  i_len,
    input  wire t_cell_ctrl            i_ctrl,
    input  wire logic [DATA_WIDTH-1:0] i_new,
    input  wire logic [DATA_WIDTH-1:0] i_left,
    input  wire logic [DATA_WIDTH-1:0] i_right,
    output logic      [DATA_WIDTH-1:0] o_data,
    output logic                       o_hit,
    output logic                       o_sel
);

    localparam logic [KEY_WIDTH-1:0] MY_INDEX = KEY_WIDTH'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic                  r_hit;
    logic                  r_eq;
    logic                  r_ge;

    // Flags are taken when the transaction is accepted, against the unchanged contents.
    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            r_hit <= (r_data == i_key) && (MY_INDEX < i_len);
            r_eq  <= (MY_INDEX == i_pos);
            r_ge  <= (MY_INDEX >= i_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert && r_eq) begin
            r_data <= i_new;
        end else if (i_ctrl.insert && r_ge) begin
            r_data <= i_left;
        end else if (i_ctrl.remove && r_ge) begin
            r_data <= i_right;
        end else if (i_ctrl.replace && r_eq) begin
            r_data <= i_new;
        end
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;
    assign o_sel  = r_eq;

endmodule

`default_nettype wire

// ----- hdl/indexed_ordered_list.sv -----
// Indexed ordered list top level: a chain of entry cells with command control and output register.
// A transaction's index and compare flags are captured in every cell at its accepting edge; the
// commit then shifts or writes in all cells at once and forms the result in the output register.
// No new transaction is accepted until the previous one has committed.
// The commit waits while a previous result is still held by a stalled output.
// Reset (synchronous, active low) empties the list and clears append-at-front; entry words
// are not cleared and are never read before they are written.
`default_nettype none

module indexed_ordered_list
    import iol_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // command channel
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [CMD_WIDTH-1:0]    i_command,
    input  wire logic [POS_WIDTH-1:0]    i_position,
    input  wire logic [VALUE_WIDTH-1:0]  i_value,
    // result channel
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic      [STATUS_WIDTH-1:0] o_status,
    output logic      [VALUE_WIDTH-1:0]  o_read_value,
    output logic      [FOUND_WIDTH-1:0]  o_found_position,
    output logic      [COUNT_WIDTH-1:0]  o_entry_count,
    // configuration channel
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic                    i_cfg_data
);

    // Length needs to hold CAPACITY itself; cell compares run at the wider of length and position.
    localparam int LEN_WIDTH = $clog2(CAPACITY + 1);
    localparam int KEY_WIDTH = (LEN_WIDTH > POS_WIDTH) ? LEN_WIDTH : POS_WIDTH;
    localparam logic [LEN_WIDTH-1:0] FULL_LEN = LEN_WIDTH'(CAPACITY);

    logic                    r_busy;
    logic                    r_add_front;
    logic [LEN_WIDTH-1:0]    r_len;
    logic [LEN_WIDTH-1:0]    n_len;
    logic [CMD_WIDTH-1:0]    r_cmd;
    logic [KEY_WIDTH-1:0]    r_pos;
    logic [KEY_WIDTH-1:0]    n_pos;
    logic [DATA_WIDTH-1:0]   r_value;

    logic                    r_out_valid;
    logic [STATUS_WIDTH-1:0] r_status;
    logic [STATUS_WIDTH-1:0] n_status;
    logic [VALUE_WIDTH-1:0]  r_read_value;
    logic [VALUE_WIDTH-1:0]  n_read_value;
    logic [FOUND_WIDTH-1:0]  r_found;
    logic [FOUND_WIDTH-1:0]  n_found;

    logic                    w_accept;
    logic                    w_commit;
    logic [EXT_WIDTH-1:0]    w_value_ext;
    logic [DATA_WIDTH-1:0]   w_key;
    logic [KEY_WIDTH-1:0]    w_len_key;
    logic [KEY_WIDTH-1:0]    w_len_cur;
    logic                    w_full;
    t_cell_ctrl              w_ctrl;

    logic [DATA_WIDTH-1:0]   w_data [CAPACITY];
    logic [CAPACITY-1:0]     w_hit;
    logic [CAPACITY-1:0]     w_sel;
    logic [DATA_WIDTH-1:0]   w_read_raw;
    logic [EXT_WIDTH-1:0]    w_read_ext;
    logic [KEY_WIDTH-1:0]    w_found_key;
    logic                    w_any_hit;

    // Accept a new transaction whenever no command is in flight; a held result does not block.
    assign o_stall     = r_busy;
    assign w_accept    = i_valid && !r_busy;
    // Commit once the output register is free or is being emptied this cycle.
    assign w_commit    = r_busy && (!r_out_valid || !i_stall);
    assign o_cfg_ready = 1'b1;

    // Bring the 32-bit field to the stored word width, sign-extending when wider.
    assign w_value_ext = EXT_WIDTH'(signed'(i_value));
    assign w_key       = w_value_ext[DATA_WIDTH-1:0];
    assign w_len_cur   = KEY_WIDTH'(r_len);
    assign w_len_key   = w_len_cur;

    // Append resolves to an insert at the front or at the tail.
    always_comb begin
        if (i_command == CMD_APPEND) begin
            n_pos = r_add_front ? '0 : w_len_cur;
        end else begin
            n_pos = KEY_WIDTH'(i_position);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add_front <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_add_front <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_command;
            r_pos   <= n_pos;
            r_value <= w_key;
        end
    end

    // Chain of cells; each takes its left neighbor on insert and its right one on delete.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_data[g];
        end else begin : g_inner_l
            assign w_left = w_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_inner_r
            assign w_right = w_data[g+1];
        end

        iol_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .KEY_WIDTH  (KEY_WIDTH),
            .INDEX      (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_capture (w_accept),
            .i_key     (w_key),
            .i_pos     (n_pos),
            .i_len     (w_len_key),
            .i_ctrl    (w_ctrl),
            .i_new     (r_value),
            .i_left    (w_left),
            .i_right   (w_right),
            .o_data    (w_data[g]),
            .o_hit     (w_hit[g]),
            .o_sel     (w_sel[g])
        );
    end

    // Gather the selected word and the lowest matching cell.
    always_comb begin
        w_read_raw  = '0;
        w_found_key = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_read_raw = w_read_raw | (w_sel[i] ? w_data[i] : '0);
        end
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (w_hit[i]) begin
                w_found_key = KEY_WIDTH'(i);
            end
        end
    end

    assign w_any_hit  = |w_hit;
    assign w_read_ext = EXT_WIDTH'(signed'(w_read_raw));
    assign w_full     = (r_len == FULL_LEN);

    // Decide status, the new length and the order broadcast to the cells.
    always_comb begin
        n_status     = ST_OK;
        n_read_value = '0;
        n_found      = '0;
        n_len        = r_len;
        w_ctrl       = '0;
        case (r_cmd)
            CMD_APPEND: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctrl.insert = 1'b1;
                    n_len         = r_len + 1'b1;
                end
            end
            CMD_INSERT: begin
                if (r_pos > w_len_cur) begin
                    n_status = ST_BAD_INDEX;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctrl.insert = 1'b1;
                    n_len         = r_len + 1'b1;
                end
            end
            CMD_DELETE: begin
                if (r_pos >= w_len_cur) begin
                    n_status = ST_BAD_INDEX;
                end else begin
                    w_ctrl.remove = 1'b1;
                    n_len         = r_len - 1'b1;
                end
            end
            CMD_REPLACE: begin
                if (r_pos >= w_len_cur) begin
                    n_status = ST_BAD_INDEX;
                end else begin
                    w_ctrl.replace = 1'b1;
                end
            end
            CMD_READ: begin
                if (r_pos >= w_len_cur) begin
                    n_status = ST_BAD_INDEX;
                end else begin
                    n_read_value = w_read_ext[VALUE_WIDTH-1:0];
                end
            end
            CMD_LOCATE: begin
                if (w_any_hit) begin
                    n_found = w_found_key[FOUND_WIDTH-1:0];
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
        // Hold everything until the commit cycle.
        if (!w_commit) begin
            w_ctrl = '0;
            n_len  = r_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_commit) begin
                r_busy <= 1'b0;
            end
            r_len <= n_len;
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_status     <= n_status;
            r_read_value <= n_read_value;
            r_found      <= n_found;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_read_value     = r_read_value;
    assign o_found_position = r_found;
    assign o_entry_count    = w_len_cur[COUNT_WIDTH-1:0];

    // The list never grows past its capacity.
    a_len_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= FULL_LEN)
        else $error("list length beyond capacity");

    // An accepted transaction always leaves a command in flight.
    a_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy)
        else $error("accepted transaction not in flight");

    // A commit always presents a result in the next cycle.
    a_commit_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> o_valid)
        else $error("commit without result");

    // A full status is only reported when the list is at capacity.
    a_full_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> w_full)
        else $error("full status with room left");

endmodule

`default_nettype wire
